/* rtl/core/ppcc_pkg.sv */
// ----------------------------------------------------------------------------
// ppcc_pkg
// Shared constants for the purge pump cycle controller: field widths, mode
// and event codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package ppcc_pkg;

   // field widths
   localparam int TIME_W   = 32;
   localparam int TEMP_W   = 16;
   localparam int FLOW_W   = 16;
   localparam int CNT_W    = 8;
   localparam int DAILY_W  = 12;
   localparam int HOUR_W   = 5;
   localparam int MIN_W    = 6;
   localparam int MODE_W   = 3;
   localparam int EVENT_W  = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // sensor age limits in microseconds
   localparam logic [TIME_W-1:0] FLOW_FRESH_US = TIME_W'(15 * 1000000);
   localparam logic [TIME_W-1:0] HOLD_OFF_US   = TIME_W'(30 * 1000000);

   // minutes per hour for the daily trigger compare
   localparam logic [DAILY_W-1:0] MINUTES_PER_HOUR = DAILY_W'(60);

   // operating modes
   localparam logic [MODE_W-1:0] MODE_WAIT  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_OFF   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ON    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_PAUSE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_EMERG = 3'd4;

   // event codes
   localparam logic [EVENT_W-1:0] EV_NONE        = 4'd0;
   localparam logic [EVENT_W-1:0] EV_DAILY_START = 4'd1;
   localparam logic [EVENT_W-1:0] EV_LOW_START   = 4'd2;
   localparam logic [EVENT_W-1:0] EV_PAUSE       = 4'd3;
   localparam logic [EVENT_W-1:0] EV_RESUME      = 4'd4;
   localparam logic [EVENT_W-1:0] EV_RUN_DONE    = 4'd5;
   localparam logic [EVENT_W-1:0] EV_EMERGENCY   = 4'd6;
   localparam logic [EVENT_W-1:0] EV_SAFE        = 4'd7;
   localparam logic [EVENT_W-1:0] EV_MANUAL_OFF  = 4'd8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SAFE_TEMP_HIGH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAFE_TEMP_LOW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOW_THRESHOLD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ON_SECONDS     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PAUSE_SECONDS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CYCLE_TOTAL    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DAILY_TIME     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_EXPIRY    = 3'd7;

   // register reset values
   localparam logic signed [TEMP_W-1:0]  RST_SAFE_TEMP_HIGH = 16'sd1280;
   localparam logic signed [TEMP_W-1:0]  RST_SAFE_TEMP_LOW  = 16'sd1120;
   localparam logic [FLOW_W-1:0]         RST_FLOW_THRESHOLD = 16'd100;
   localparam logic [TIME_W-1:0]         RST_ON_SECONDS     = 32'd60;
   localparam logic [TIME_W-1:0]         RST_PAUSE_SECONDS  = 32'd60;
   localparam logic [CNT_W-1:0]          RST_CYCLE_TOTAL    = 8'd3;
   localparam logic signed [DAILY_W-1:0] RST_DAILY_TIME     = -12'sd1;
   localparam logic [TIME_W-1:0]         RST_TEMP_EXPIRY    = 32'd15000000;

endpackage

/* rtl/core/purge_pump_cycle_controller.sv */
// ----------------------------------------------------------------------------
// purge_pump_cycle_controller
// Per-tick purge pump sequencer: waits for fresh flow, then runs off, on,
// pause and emergency with daily and low-flow run starts.
// ----------------------------------------------------------------------------
// A tick goes through the input register, then the result register; the state update
// is a single compare-and-select pass. Throughput: one tick per clock unless a result
// is held. A held result does not block intake while the input register is free.
// Reset: synchronous active high; mode goes to waiting, counters and phase clear,
// configuration registers return to their default values.
module purge_pump_cycle_controller (
   input  logic                                   clock,
   input  logic                                   reset,
   // tick input
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [ppcc_pkg::TIME_W-1:0]            req_now_seconds,
   input  logic signed [ppcc_pkg::TEMP_W-1:0]     req_temp_high,
   input  logic [ppcc_pkg::TIME_W-1:0]            req_temp_age,
   input  logic [ppcc_pkg::FLOW_W-1:0]            req_flow_value,
   input  logic [ppcc_pkg::TIME_W-1:0]            req_flow_age,
   input  logic                                   req_circ_pump_on,
   input  logic [ppcc_pkg::TIME_W-1:0]            req_circ_state_age,
   input  logic                                   req_manual_switch,
   input  logic                                   req_clock_valid,
   input  logic [ppcc_pkg::HOUR_W-1:0]            req_hour_of_day,
   input  logic [ppcc_pkg::MIN_W-1:0]             req_minute_of_hour,
   // result output
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_pump_drive,
   output logic [ppcc_pkg::MODE_W-1:0]            rsp_mode_code,
   output logic [ppcc_pkg::EVENT_W-1:0]           rsp_event_code,
   output logic [ppcc_pkg::CNT_W-1:0]             rsp_cycles_left,
   // configuration write port
   input  logic                                   csr_wr_en,
   input  logic [ppcc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ppcc_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   // configuration registers
   logic signed [ppcc_pkg::TEMP_W-1:0]  safe_temp_high_ff;
   logic signed [ppcc_pkg::TEMP_W-1:0]  safe_temp_low_ff;
   logic [ppcc_pkg::FLOW_W-1:0]         flow_threshold_ff;
   logic [ppcc_pkg::TIME_W-1:0]         on_seconds_ff;
   logic [ppcc_pkg::TIME_W-1:0]         pause_seconds_ff;
   logic [ppcc_pkg::CNT_W-1:0]          cycle_total_ff;
   logic signed [ppcc_pkg::DAILY_W-1:0] daily_time_ff;
   logic [ppcc_pkg::TIME_W-1:0]         temp_expiry_ff;

   // input register
   logic                                in_valid_ff;
   logic [ppcc_pkg::TIME_W-1:0]         now_ff;
   logic signed [ppcc_pkg::TEMP_W-1:0]  temp_ff;
   logic [ppcc_pkg::TIME_W-1:0]         temp_age_ff;
   logic [ppcc_pkg::FLOW_W-1:0]         flow_ff;
   logic [ppcc_pkg::TIME_W-1:0]         flow_age_ff;
   logic                                circ_on_ff;
   logic [ppcc_pkg::TIME_W-1:0]         circ_age_ff;
   logic                                manual_ff;
   logic                                clock_ok_ff;
   logic [ppcc_pkg::HOUR_W-1:0]         hour_ff;
   logic [ppcc_pkg::MIN_W-1:0]          minute_ff;

   // controller state
   logic [ppcc_pkg::MODE_W-1:0]         mode_ff,        mode_in;
   logic [ppcc_pkg::CNT_W-1:0]          remaining_ff,   remaining_in;
   logic [ppcc_pkg::TIME_W-1:0]         phase_start_ff, phase_start_in;
   logic [ppcc_pkg::MIN_W-1:0]          last_minute_ff, last_minute_in;
   logic [ppcc_pkg::EVENT_W-1:0]        event_in;

   // result register
   logic                                out_valid_ff;
   logic                                out_pump_ff;
   logic [ppcc_pkg::MODE_W-1:0]         out_mode_ff;
   logic [ppcc_pkg::EVENT_W-1:0]        out_event_ff;
   logic [ppcc_pkg::CNT_W-1:0]          out_cycles_ff;

   // handshake
   logic                                out_free;
   logic                                advance;

   // helper terms
   logic [ppcc_pkg::DAILY_W-1:0]        minute_of_day;
   logic [ppcc_pkg::TIME_W-1:0]         elapsed;
   logic                                flow_fresh;
   logic                                daily_hit;
   logic                                low_flow;
   logic [ppcc_pkg::CNT_W-1:0]          run_cycles;

   // pipeline flow control
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         safe_temp_high_ff <= ppcc_pkg::RST_SAFE_TEMP_HIGH;
         safe_temp_low_ff  <= ppcc_pkg::RST_SAFE_TEMP_LOW;
         flow_threshold_ff <= ppcc_pkg::RST_FLOW_THRESHOLD;
         on_seconds_ff     <= ppcc_pkg::RST_ON_SECONDS;
         pause_seconds_ff  <= ppcc_pkg::RST_PAUSE_SECONDS;
         cycle_total_ff    <= ppcc_pkg::RST_CYCLE_TOTAL;
         daily_time_ff     <= ppcc_pkg::RST_DAILY_TIME;
         temp_expiry_ff    <= ppcc_pkg::RST_TEMP_EXPIRY;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ppcc_pkg::CSR_SAFE_TEMP_HIGH:
               safe_temp_high_ff <= csr_wdata[ppcc_pkg::TEMP_W-1:0];
            ppcc_pkg::CSR_SAFE_TEMP_LOW:
               safe_temp_low_ff  <= csr_wdata[ppcc_pkg::TEMP_W-1:0];
            ppcc_pkg::CSR_FLOW_THRESHOLD:
               flow_threshold_ff <= csr_wdata[ppcc_pkg::FLOW_W-1:0];
            ppcc_pkg::CSR_ON_SECONDS:
               on_seconds_ff     <= csr_wdata[ppcc_pkg::TIME_W-1:0];
            ppcc_pkg::CSR_PAUSE_SECONDS:
               pause_seconds_ff  <= csr_wdata[ppcc_pkg::TIME_W-1:0];
            ppcc_pkg::CSR_CYCLE_TOTAL:
               cycle_total_ff    <= csr_wdata[ppcc_pkg::CNT_W-1:0];
            ppcc_pkg::CSR_DAILY_TIME:
               daily_time_ff     <= csr_wdata[ppcc_pkg::DAILY_W-1:0];
            ppcc_pkg::CSR_TEMP_EXPIRY:
               temp_expiry_ff    <= csr_wdata[ppcc_pkg::TIME_W-1:0];
            default: ;
         endcase
      end
   end

   // input register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         now_ff      <= req_now_seconds;
         temp_ff     <= req_temp_high;
         temp_age_ff <= req_temp_age;
         flow_ff     <= req_flow_value;
         flow_age_ff <= req_flow_age;
         circ_on_ff  <= req_circ_pump_on;
         circ_age_ff <= req_circ_state_age;
         manual_ff   <= req_manual_switch;
         clock_ok_ff <= req_clock_valid;
         hour_ff     <= req_hour_of_day;
         minute_ff   <= req_minute_of_hour;
      end
   end

   // trigger terms
   assign minute_of_day = ppcc_pkg::DAILY_W'(hour_ff) * ppcc_pkg::MINUTES_PER_HOUR
                          + ppcc_pkg::DAILY_W'(minute_ff);
   assign flow_fresh    = flow_age_ff < ppcc_pkg::FLOW_FRESH_US;
   assign daily_hit     = clock_ok_ff && !daily_time_ff[ppcc_pkg::DAILY_W-1]
                          && (minute_ff != last_minute_ff)
                          && (ppcc_pkg::DAILY_W'(minute_ff) < ppcc_pkg::MINUTES_PER_HOUR)
                          && (minute_of_day == daily_time_ff);
   assign low_flow      = flow_fresh && circ_on_ff && (flow_ff <= flow_threshold_ff)
                          && (circ_age_ff > ppcc_pkg::HOLD_OFF_US);
   assign elapsed       = now_ff - phase_start_ff;
   assign run_cycles    = (cycle_total_ff == '0) ? ppcc_pkg::CNT_W'(1) : cycle_total_ff;

   // next state for one tick
   always_comb begin
      mode_in        = mode_ff;
      remaining_in   = remaining_ff;
      phase_start_in = phase_start_ff;
      last_minute_in = last_minute_ff;
      event_in       = ppcc_pkg::EV_NONE;

      if (mode_ff == ppcc_pkg::MODE_WAIT) begin
         // hold off until flow is fresh
         if (flow_fresh) begin
            mode_in        = ppcc_pkg::MODE_OFF;
            remaining_in   = '0;
            phase_start_in = '0;
            last_minute_in = '0;
         end
      end else begin
         // minute tracking for the daily trigger
         if (clock_ok_ff && !daily_time_ff[ppcc_pkg::DAILY_W-1]) begin
            last_minute_in = minute_ff;
         end

         // over-temperature entry and exit
         if (temp_age_ff < temp_expiry_ff) begin
            if (mode_ff == ppcc_pkg::MODE_EMERG) begin
               if (temp_ff < safe_temp_low_ff) begin
                  mode_in  = ppcc_pkg::MODE_OFF;
                  event_in = ppcc_pkg::EV_SAFE;
               end
            end else if (temp_ff >= safe_temp_high_ff) begin
               mode_in      = ppcc_pkg::MODE_EMERG;
               remaining_in = '0;
               event_in     = ppcc_pkg::EV_EMERGENCY;
            end
         end

         // run sequencing
         priority if (mode_in == ppcc_pkg::MODE_OFF) begin
            if (!manual_ff && (daily_hit || low_flow)) begin
               mode_in        = ppcc_pkg::MODE_ON;
               phase_start_in = now_ff;
               remaining_in   = run_cycles - ppcc_pkg::CNT_W'(1);
               event_in       = daily_hit ? ppcc_pkg::EV_DAILY_START
                                          : ppcc_pkg::EV_LOW_START;
            end
         end else if (mode_in == ppcc_pkg::MODE_ON) begin
            if (elapsed >= on_seconds_ff) begin
               mode_in        = ppcc_pkg::MODE_PAUSE;
               phase_start_in = now_ff;
               event_in       = ppcc_pkg::EV_PAUSE;
            end
         end else if (mode_in == ppcc_pkg::MODE_PAUSE) begin
            if (elapsed >= pause_seconds_ff) begin
               if (remaining_ff != '0) begin
                  mode_in        = ppcc_pkg::MODE_ON;
                  phase_start_in = now_ff;
                  remaining_in   = remaining_ff - ppcc_pkg::CNT_W'(1);
                  event_in       = ppcc_pkg::EV_RESUME;
               end else begin
                  mode_in  = ppcc_pkg::MODE_OFF;
                  event_in = ppcc_pkg::EV_RUN_DONE;
               end
            end
         end else begin
            // emergency holds until a safe reading
         end

         // manual switch aborts a run
         if (manual_ff && (mode_in == ppcc_pkg::MODE_ON || mode_in == ppcc_pkg::MODE_PAUSE)) begin
            mode_in      = ppcc_pkg::MODE_OFF;
            remaining_in = '0;
            event_in     = ppcc_pkg::EV_MANUAL_OFF;
         end
      end
   end

   // controller state update
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= ppcc_pkg::MODE_WAIT;
         remaining_ff   <= '0;
         phase_start_ff <= '0;
         last_minute_ff <= '0;
      end else if (advance) begin
         mode_ff        <= mode_in;
         remaining_ff   <= remaining_in;
         phase_start_ff <= phase_start_in;
         last_minute_ff <= last_minute_in;
      end
   end

   // result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         out_pump_ff   <= (mode_in == ppcc_pkg::MODE_ON) || (mode_in == ppcc_pkg::MODE_EMERG);
         out_mode_ff   <= mode_in;
         out_event_ff  <= event_in;
         out_cycles_ff <= remaining_in;
      end
   end

   // outputs
   assign rsp_valid       = out_valid_ff;
   assign rsp_pump_drive  = out_pump_ff;
   assign rsp_mode_code   = out_mode_ff;
   assign rsp_event_code  = out_event_ff;
   assign rsp_cycles_left = out_cycles_ff;

   // once flow was seen fresh the controller never waits again
   a_no_return_to_wait: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != ppcc_pkg::MODE_WAIT) |=> (mode_ff != ppcc_pkg::MODE_WAIT))
      else $error("controller returned to waiting mode");

   // pump command follows the reported mode
   a_pump_matches_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pump_drive ==
         ((rsp_mode_code == ppcc_pkg::MODE_ON) || (rsp_mode_code == ppcc_pkg::MODE_EMERG))))
      else $error("pump drive disagrees with mode");

   // no cycles pending outside a run
   a_no_cycles_outside_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_mode_code == ppcc_pkg::MODE_OFF
                     || rsp_mode_code == ppcc_pkg::MODE_EMERG
                     || rsp_mode_code == ppcc_pkg::MODE_WAIT)) |-> (rsp_cycles_left == '0))
      else $error("cycles left outside a run");

   // waiting mode reports no event
   a_wait_is_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mode_code == ppcc_pkg::MODE_WAIT) |-> (rsp_event_code == ppcc_pkg::EV_NONE))
      else $error("event reported while waiting");

endmodule
